>>> rtl/core/pdc_pkg.sv
// ----------------------------------------------------------------------------
// pdc_pkg
// Shared types, constants and the CRC-32 byte update for the packet deframer
// with header and payload CRC-32 checks.
// ----------------------------------------------------------------------------
package pdc_pkg;

  // Largest payload length accepted before a length error is flagged
  localparam logic [14:0] MaxPayload = 15'd512;

  // Depth of the transaction queue between the front and back units
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // CRC-32 (reflected polynomial) constants
  localparam logic [31:0] CrcPoly = 32'hEDB88320;
  localparam logic [31:0] CrcInit = 32'hFFFFFFFF;

  // Packet type carrying a payload
  localparam logic [1:0] PtypeData = 2'd1;

  // Mask that clears the truncated bit of the first header byte for the CRC
  localparam logic [7:0] HdrCrcMask = 8'hDF;

  // Summary status codes
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_TYPE = 3'd1,
    ST_INCONS   = 3'd2,
    ST_LEN_BIG  = 3'd3,
    ST_HDR_CRC  = 3'd4,
    ST_PAY_CRC  = 3'd5
  } status_e;

  // Work to be done by the back unit for one byte
  typedef enum logic [2:0] {
    OP_NONE,   // byte carries nothing the back unit needs
    OP_CRC,    // fold byte into the running CRC
    OP_PAY,    // fold byte into the running CRC and pass it out
    OP_RX,     // shift byte into the received CRC
    OP_HCHK,   // shift last header CRC byte in, compare, restart the CRC
    OP_PCHK    // shift last payload CRC byte in and compare
  } op_e;

  // Input transaction
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } in_t;

  // Output transaction
  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic [1:0]  ptype;
    logic        truncated;
    logic [4:0]  window;
    logic [14:0] length;
    logic [7:0]  seqnum;
    logic [31:0] timestamp;
    logic [2:0]  status;
  } out_t;

  // Classified byte handed from the front unit to the back unit
  typedef struct packed {
    op_e         op;
    logic [7:0]  data;
    logic        last;
    logic [1:0]  ptype;
    logic        truncated;
    logic [4:0]  window;
    logic [14:0] length;
    logic [7:0]  seqnum;
    logic [31:0] timestamp;
    status_e     early_err;
    logic        count_bad;
  } qent_t;

  // One byte of the reflected CRC-32, eight bit steps
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (CrcPoly & {32{c[0]}});
    end
    return c;
  endfunction

endpackage

>>> rtl/core/pdc_front.sv
// ----------------------------------------------------------------------------
// pdc_front
// Accepts packet bytes, tracks the position within the packet, latches the
// header fields and tags each byte with the work the back unit must do.
// ----------------------------------------------------------------------------
module pdc_front #(
  parameter logic [14:0] MaxPayload = pdc_pkg::MaxPayload
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  pdc_pkg::in_t    in_i,
  input  logic            push_i,
  output pdc_pkg::qent_t  ent_o
);

  logic [15:0]      cnt_q, cnt_d;
  logic             len2_q, len2_d;
  logic [1:0]       ptype_q, ptype_d;
  logic             tr_q, tr_d;
  logic [4:0]       win_q, win_d;
  logic [14:0]      len_q, len_d;
  logic [7:0]       seq_q, seq_d;
  logic [31:0]      ts_q, ts_d;
  pdc_pkg::status_e err_q, err_d;

  logic [7:0]       b;
  logic [15:0]      hl, hdr, p0, pay_end, crc_end, ts_off, hl_n, expected;
  logic             pay_exp, pay_exp_n, len_done;
  pdc_pkg::op_e     op;
  logic [7:0]       crc_data;

  assign b = in_i.data_byte;

  // Classify the byte and work out the next header state
  always_comb begin
    cnt_d    = cnt_q;
    len2_d   = len2_q;
    ptype_d  = ptype_q;
    tr_d     = tr_q;
    win_d    = win_q;
    len_d    = len_q;
    seq_d    = seq_q;
    ts_d     = ts_q;
    err_d    = err_q;
    op       = pdc_pkg::OP_NONE;
    crc_data = b;
    len_done = 1'b0;

    hl      = 16'd2 + {15'd0, len2_q};
    hdr     = hl + 16'd5;
    p0      = hl + 16'd9;
    pay_end = p0 + {1'b0, len_q};
    crc_end = pay_end + 16'd4;
    ts_off  = cnt_q - hl - 16'd1;
    pay_exp = (ptype_q == pdc_pkg::PtypeData) && !tr_q && (len_q != 15'd0) &&
              (err_q == pdc_pkg::ST_OK);

    if (cnt_q == 16'd0) begin
      ptype_d  = b[7:6];
      tr_d     = b[5];
      win_d    = b[4:0];
      if (b[7:6] == 2'd0) begin
        err_d = pdc_pkg::ST_BAD_TYPE;
      end else if (b[7:6] != pdc_pkg::PtypeData && b[5]) begin
        err_d = pdc_pkg::ST_INCONS;
      end
      op       = pdc_pkg::OP_CRC;
      crc_data = b & pdc_pkg::HdrCrcMask;
    end else if (cnt_q == 16'd1) begin
      op = pdc_pkg::OP_CRC;
      if (b[7]) begin
        len2_d = 1'b1;
        len_d  = {b[6:0], 8'd0};
      end else begin
        len_d    = {7'd0, b};
        len_done = 1'b1;
      end
    end else if (cnt_q == 16'd2 && len2_q) begin
      op       = pdc_pkg::OP_CRC;
      len_d    = len_q | {7'd0, b};
      len_done = 1'b1;
    end else if (cnt_q == hl) begin
      op    = pdc_pkg::OP_CRC;
      seq_d = b;
    end else if (cnt_q > hl && cnt_q < hdr) begin
      op = pdc_pkg::OP_CRC;
      case (ts_off[1:0])
        2'd0:    ts_d[7:0]   = b;
        2'd1:    ts_d[15:8]  = b;
        2'd2:    ts_d[23:16] = b;
        default: ts_d[31:24] = b;
      endcase
    end else if (cnt_q >= hdr && cnt_q < p0) begin
      op = (cnt_q == p0 - 16'd1) ? pdc_pkg::OP_HCHK : pdc_pkg::OP_RX;
    end else if (pay_exp && cnt_q < pay_end) begin
      op = pdc_pkg::OP_PAY;
    end else if (pay_exp && cnt_q < crc_end) begin
      op = (cnt_q == crc_end - 16'd1) ? pdc_pkg::OP_PCHK : pdc_pkg::OP_RX;
    end

    // Flag an oversized length once it is complete
    if (len_done && err_q == pdc_pkg::ST_OK && len_d > MaxPayload) begin
      err_d = pdc_pkg::ST_LEN_BIG;
    end

    // Saturating byte count
    if (cnt_q != 16'hFFFF) begin
      cnt_d = cnt_q + 16'd1;
    end

    // Expected packet size from the updated header
    hl_n      = 16'd2 + {15'd0, len2_d};
    pay_exp_n = (ptype_d == pdc_pkg::PtypeData) && !tr_d && (len_d != 15'd0) &&
                (err_d == pdc_pkg::ST_OK);
    expected  = pay_exp_n ? (hl_n + 16'd13 + {1'b0, len_d}) : (hl_n + 16'd9);
  end

  // Build the queue entry
  always_comb begin
    ent_o.op        = op;
    ent_o.data      = crc_data;
    ent_o.last      = in_i.last;
    ent_o.ptype     = ptype_d;
    ent_o.truncated = tr_d;
    ent_o.window    = win_d;
    ent_o.length    = len_d;
    ent_o.seqnum    = seq_d;
    ent_o.timestamp = ts_d;
    ent_o.early_err = err_d;
    ent_o.count_bad = (cnt_d != expected);
  end

  // Advance header state; return to reset after the final byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      len2_q  <= 1'b0;
      ptype_q <= '0;
      tr_q    <= 1'b0;
      win_q   <= '0;
      len_q   <= '0;
      seq_q   <= '0;
      ts_q    <= '0;
      err_q   <= pdc_pkg::ST_OK;
    end else if (push_i && in_i.last) begin
      cnt_q   <= '0;
      len2_q  <= 1'b0;
      ptype_q <= '0;
      tr_q    <= 1'b0;
      win_q   <= '0;
      len_q   <= '0;
      seq_q   <= '0;
      ts_q    <= '0;
      err_q   <= pdc_pkg::ST_OK;
    end else if (push_i) begin
      cnt_q   <= cnt_d;
      len2_q  <= len2_d;
      ptype_q <= ptype_d;
      tr_q    <= tr_d;
      win_q   <= win_d;
      len_q   <= len_d;
      seq_q   <= seq_d;
      ts_q    <= ts_d;
      err_q   <= err_d;
    end
  end

endmodule

>>> rtl/core/pdc_queue.sv
// ----------------------------------------------------------------------------
// pdc_queue
// Short register queue of classified bytes between the front and back units.
// ----------------------------------------------------------------------------
module pdc_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  pdc_pkg::qent_t  ent_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output pdc_pkg::qent_t  ent_o
);

  pdc_pkg::qent_t                  mem_q [pdc_pkg::QDepth];
  logic [pdc_pkg::QPtrW-1:0]       wr_q, wr_d, rd_q, rd_d;
  logic [pdc_pkg::QCntW-1:0]       cnt_q, cnt_d;

  assign full_o  = (cnt_q == pdc_pkg::QCntW'(pdc_pkg::QDepth));
  assign empty_o = (cnt_q == '0);
  assign ent_o   = mem_q[rd_q];

  // Advance pointers with wrap and track the fill level
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == pdc_pkg::QPtrW'(pdc_pkg::QDepth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == pdc_pkg::QPtrW'(pdc_pkg::QDepth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= ent_i;
    end
  end

endmodule

>>> rtl/core/pdc_back.sv
// ----------------------------------------------------------------------------
// pdc_back
// Runs the CRC-32, checks the received header and payload CRCs, and forms
// payload and summary transactions in an output register.
// ----------------------------------------------------------------------------
module pdc_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            empty_i,
  input  pdc_pkg::qent_t  ent_i,
  output logic            pop_o,
  output pdc_pkg::out_t   out_o,
  output logic            out_valid_o,
  input  logic            out_stall_i
);

  logic [31:0]   crc_q, crc_d;
  logic [31:0]   rx_q, rx_d;
  logic          hbad_q, hbad_d;
  logic          oval_q, oval_d;
  pdc_pkg::out_t out_q, out_d;

  logic [31:0]   crc_next, rx_next;
  logic          pay_bad, emits;
  logic [2:0]    status;

  assign crc_next = pdc_pkg::crc32_byte(crc_q, ent_i.data);
  assign rx_next  = {rx_q[23:0], ent_i.data};
  assign emits    = ent_i.last || (ent_i.op == pdc_pkg::OP_PAY);
  assign pop_o    = !empty_i && (!emits || !oval_q || !out_stall_i);

  // Carry out the byte's CRC work
  always_comb begin
    crc_d   = crc_q;
    rx_d    = rx_q;
    hbad_d  = hbad_q;
    pay_bad = 1'b0;
    unique case (ent_i.op) inside
      pdc_pkg::OP_CRC,
      pdc_pkg::OP_PAY: begin
        crc_d = crc_next;
      end
      pdc_pkg::OP_RX: begin
        rx_d = rx_next;
      end
      pdc_pkg::OP_HCHK: begin
        hbad_d = (~crc_q != rx_next);
        crc_d  = pdc_pkg::CrcInit;
        rx_d   = '0;
      end
      pdc_pkg::OP_PCHK: begin
        rx_d    = rx_next;
        pay_bad = (~crc_q != rx_next);
      end
      default: begin
      end
    endcase

    // Pick the summary status by priority
    if (ent_i.early_err != pdc_pkg::ST_OK) begin
      status = ent_i.early_err;
    end else if (ent_i.count_bad) begin
      status = pdc_pkg::ST_INCONS;
    end else if (hbad_d) begin
      status = pdc_pkg::ST_HDR_CRC;
    end else if (pay_bad) begin
      status = pdc_pkg::ST_PAY_CRC;
    end else begin
      status = pdc_pkg::ST_OK;
    end

    // Restart the checks after the final byte
    if (ent_i.last) begin
      crc_d  = pdc_pkg::CrcInit;
      rx_d   = '0;
      hbad_d = 1'b0;
    end
  end

  // Form the output transaction
  always_comb begin
    oval_d = oval_q;
    out_d  = out_q;
    if (pop_o && emits) begin
      oval_d = 1'b1;
      if (ent_i.last) begin
        out_d.kind         = 1'b1;
        out_d.payload_byte = '0;
        out_d.ptype        = ent_i.ptype;
        out_d.truncated    = ent_i.truncated;
        out_d.window       = ent_i.window;
        out_d.length       = ent_i.length;
        out_d.seqnum       = ent_i.seqnum;
        out_d.timestamp    = ent_i.timestamp;
        out_d.status       = status;
      end else begin
        out_d              = '0;
        out_d.payload_byte = ent_i.data;
      end
    end else if (!out_stall_i) begin
      oval_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q  <= pdc_pkg::CrcInit;
      rx_q   <= '0;
      hbad_q <= 1'b0;
      oval_q <= 1'b0;
    end else begin
      oval_q <= oval_d;
      if (pop_o) begin
        crc_q  <= crc_d;
        rx_q   <= rx_d;
        hbad_q <= hbad_d;
      end
    end
  end

  // Hold the output payload
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_o       = out_q;
  assign out_valid_o = oval_q;

endmodule

>>> rtl/core/packet_deframer_crc32_check_unit.sv
// An accepted byte is registered in the queue, then its payload or summary in the output register.
// Throughput: one byte per cycle while the output is not stalled, set by the byte-wide
// CRC-32 update in the back unit. A two-entry queue between front and back absorbs up
// to two transactions while the output is stalled; bytes that yield no result keep
// draining meanwhile. Reset is asynchronous and active low; it returns the header
// tracking, CRC state, queue and output register to idle at once.
// ----------------------------------------------------------------------------
// packet_deframer_crc32_check_unit
// Packet deframer: header field decode, varint length, header and payload
// CRC-32 checks, payload pass-through and a per-packet summary.
// ----------------------------------------------------------------------------
module packet_deframer_crc32_check_unit #(
  parameter logic [14:0] MaxPayload = pdc_pkg::MaxPayload
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  pdc_pkg::in_t   in_i,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  output pdc_pkg::out_t  out_o,
  output logic           out_valid_o,
  input  logic           out_stall_i
);

  pdc_pkg::qent_t front_ent, head_ent;
  logic           push, pop, full, empty;

  // Accept a transaction whenever the queue has room
  assign in_stall_o = full;
  assign push       = in_valid_i && !full;

  pdc_front #(
    .MaxPayload (MaxPayload)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .push_i (push),
    .ent_o  (front_ent)
  );

  pdc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .ent_i   (front_ent),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .ent_o   (head_ent)
  );

  pdc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .ent_i       (head_ent),
    .pop_o       (pop),
    .out_o       (out_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i)
  );

endmodule
